/* rtl/wtp_pkg.sv */
// Shared types and constants for the WebVTT timestamp parser.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package wtp_pkg;

   localparam int MS_W = 38;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;

   localparam logic [2:0] DIGIT_SAT  = 3'd4;
   localparam logic [2:0] DIGIT_MIN  = 3'd2;
   localparam logic [2:0] FRAC_DIGITS = 3'd3;
   localparam logic [1:0] COLON_MAX  = 2'd2;
   localparam logic [1:0] COLON_BAD  = 2'd3;
   localparam logic [1:0] COLON_MS   = 2'd1;
   localparam logic [1:0] COLON_HMS  = 2'd2;
   localparam logic [6:0] SMALL_CAP  = 7'd127;
   localparam logic [6:0] SIXTY      = 7'd60;

   localparam logic [21:0] MS_PER_HOUR = 22'd3600000;
   localparam logic [15:0] MS_PER_MIN  = 16'd60000;
   localparam logic [9:0]  MS_PER_SEC  = 10'd1000;

   typedef struct packed {
      logic [7:0] code;
      logic       last;
   } char_type;

   // Finished token, everything but the hours value
   typedef struct packed {
      logic       ok;
      logic [5:0] minutes;
      logic [5:0] seconds;
      logic [9:0] frac;
   } fin_type;

endpackage

`default_nettype wire

/* rtl/wtp_skid.sv */
// Two-entry input buffer for the timestamp parser: head register plus spare.
// The stall toward the sender comes straight from a flop. Uses wtp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wtp_skid (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output      logic              in_stall,
   input  wire wtp_pkg::char_type in_item,
   output      logic              hd_valid,
   output      wtp_pkg::char_type hd_item,
   input  wire logic              pop
);

   logic              hd_valid_ff, hd_valid_in;
   logic              sp_valid_ff, sp_valid_in;
   wtp_pkg::char_type hd_item_ff, hd_item_in;
   wtp_pkg::char_type sp_item_ff, sp_item_in;
   logic              accept;

   assign accept   = in_valid && !sp_valid_ff;
   assign in_stall = sp_valid_ff;
   assign hd_valid = hd_valid_ff;
   assign hd_item  = hd_item_ff;

   always_comb begin
      hd_valid_in = hd_valid_ff;
      hd_item_in  = hd_item_ff;
      sp_valid_in = sp_valid_ff;
      sp_item_in  = sp_item_ff;
      if (!hd_valid_ff || pop) begin
         // refill head from the spare first, else from the port
         if (sp_valid_ff) begin
            hd_valid_in = 1'b1;
            hd_item_in  = sp_item_ff;
            sp_valid_in = 1'b0;
         end else begin
            hd_valid_in = accept;
            hd_item_in  = in_item;
         end
      end else if (accept) begin
         sp_valid_in = 1'b1;
         sp_item_in  = in_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hd_valid_ff <= 1'b0;
         sp_valid_ff <= 1'b0;
      end else begin
         hd_valid_ff <= hd_valid_in;
         sp_valid_ff <= sp_valid_in;
      end
      hd_item_ff <= hd_item_in;
      sp_item_ff <= sp_item_in;
   end

   a_spare_needs_head : assert property (@(posedge clock) disable iff (reset)
      sp_valid_ff |-> hd_valid_ff)
      else $error("spare entry held with empty head");

endmodule

`default_nettype wire

/* rtl/wtp_field_acc.sv */
// Per-character token state of the timestamp parser: digit accumulate, field
// capture at colon and dot, error tracking. Uses wtp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wtp_field_acc #(
   parameter int HOURS_LIMIT = 65535,
   parameter int VAL_W       = 17
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              take,
   input  wire wtp_pkg::char_type item,
   output      wtp_pkg::fin_type  fin,
   output      logic [VAL_W-1:0]  fin_hours
);

   logic [1:0]       colon_count_ff, colon_count_in, cc_u;
   logic             in_fraction_ff, in_fraction_in, inf_u;
   logic [2:0]       digit_count_ff, digit_count_in, dc_u;
   logic [VAL_W-1:0] current_value_ff, current_value_in, cur_u;
   logic [VAL_W-1:0] first_field_ff, first_field_in, first_u;
   logic [6:0]       second_field_ff, second_field_in, second_u;
   logic [6:0]       seconds_value_ff, seconds_value_in, sec_u;
   logic             error_flag_ff, error_flag_in, err_u;
   logic             content_seen_ff, content_seen_in, cont_u;
   logic             trailing_space_ff, trailing_space_in, trail_u;

   logic             is_space, is_digit;
   logic [VAL_W+3:0] acc;
   logic             field_ok;

   function automatic logic [6:0] cap7(input logic [VAL_W-1:0] v);
      if (v > VAL_W'(wtp_pkg::SMALL_CAP)) begin
         return wtp_pkg::SMALL_CAP;
      end
      return 7'(v);
   endfunction

   assign is_space = (item.code == wtp_pkg::CHAR_SPACE) ||
                     (item.code >= wtp_pkg::CHAR_TAB && item.code <= wtp_pkg::CHAR_CR);
   assign is_digit = (item.code >= wtp_pkg::CHAR_ZERO) && (item.code <= wtp_pkg::CHAR_NINE);
   // digit value is the low nibble of an ASCII digit
   assign acc = (VAL_W+4)'(current_value_ff) * (VAL_W+4)'(10) + (VAL_W+4)'(item.code[3:0]);

   always_comb begin
      cc_u     = colon_count_ff;
      inf_u    = in_fraction_ff;
      dc_u     = digit_count_ff;
      cur_u    = current_value_ff;
      first_u  = first_field_ff;
      second_u = second_field_ff;
      sec_u    = seconds_value_ff;
      err_u    = error_flag_ff;
      cont_u   = content_seen_ff;
      trail_u  = trailing_space_ff;

      if (is_space) begin
         if (content_seen_ff) begin
            trail_u = 1'b1;
         end
      end else begin
         if (trailing_space_ff) begin
            err_u = 1'b1;
         end
         cont_u = 1'b1;
         if (is_digit) begin
            if (acc > (VAL_W+4)'(HOURS_LIMIT)) begin
               cur_u = VAL_W'(HOURS_LIMIT + 1);
            end else begin
               cur_u = acc[VAL_W-1:0];
            end
            if (digit_count_ff < wtp_pkg::DIGIT_SAT) begin
               dc_u = digit_count_ff + 3'd1;
            end
         end else if (item.code == wtp_pkg::CHAR_COLON) begin
            if (in_fraction_ff || colon_count_ff >= wtp_pkg::COLON_MAX) begin
               err_u = 1'b1;
               cc_u  = wtp_pkg::COLON_BAD;
            end else begin
               if (colon_count_ff == 2'd0) begin
                  first_u = current_value_ff;
               end else begin
                  second_u = cap7(current_value_ff);
               end
               cc_u = colon_count_ff + 2'd1;
            end
            if (digit_count_ff < wtp_pkg::DIGIT_MIN) begin
               err_u = 1'b1;
            end
            cur_u = '0;
            dc_u  = '0;
         end else if (item.code == wtp_pkg::CHAR_DOT) begin
            if (in_fraction_ff) begin
               err_u = 1'b1;
            end
            inf_u = 1'b1;
            sec_u = cap7(current_value_ff);
            if (digit_count_ff < wtp_pkg::DIGIT_MIN) begin
               err_u = 1'b1;
            end
            cur_u = '0;
            dc_u  = '0;
         end else begin
            err_u = 1'b1;
         end
      end
   end

   // Finish the token from the updated state
   always_comb begin
      case (cc_u)
         wtp_pkg::COLON_MS:  field_ok = first_u < VAL_W'(wtp_pkg::SIXTY);
         wtp_pkg::COLON_HMS: field_ok = (second_u < wtp_pkg::SIXTY) &&
                                        (first_u <= VAL_W'(HOURS_LIMIT));
         default:            field_ok = 1'b0;
      endcase
      fin.ok      = !err_u && inf_u && (dc_u == wtp_pkg::FRAC_DIGITS) &&
                    (sec_u < wtp_pkg::SIXTY) && field_ok;
      fin.minutes = (cc_u == wtp_pkg::COLON_MS) ? first_u[5:0] : second_u[5:0];
      fin.seconds = sec_u[5:0];
      fin.frac    = 10'(cur_u);
      fin_hours   = (cc_u == wtp_pkg::COLON_HMS) ? first_u : '0;
   end

   always_comb begin
      colon_count_in    = colon_count_ff;
      in_fraction_in    = in_fraction_ff;
      digit_count_in    = digit_count_ff;
      current_value_in  = current_value_ff;
      first_field_in    = first_field_ff;
      second_field_in   = second_field_ff;
      seconds_value_in  = seconds_value_ff;
      error_flag_in     = error_flag_ff;
      content_seen_in   = content_seen_ff;
      trailing_space_in = trailing_space_ff;
      if (take) begin
         if (item.last) begin
            // token done: clear for the next one
            colon_count_in    = '0;
            in_fraction_in    = 1'b0;
            digit_count_in    = '0;
            current_value_in  = '0;
            first_field_in    = '0;
            second_field_in   = '0;
            seconds_value_in  = '0;
            error_flag_in     = 1'b0;
            content_seen_in   = 1'b0;
            trailing_space_in = 1'b0;
         end else begin
            colon_count_in    = cc_u;
            in_fraction_in    = inf_u;
            digit_count_in    = dc_u;
            current_value_in  = cur_u;
            first_field_in    = first_u;
            second_field_in   = second_u;
            seconds_value_in  = sec_u;
            error_flag_in     = err_u;
            content_seen_in   = cont_u;
            trailing_space_in = trail_u;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         colon_count_ff    <= '0;
         in_fraction_ff    <= 1'b0;
         digit_count_ff    <= '0;
         current_value_ff  <= '0;
         first_field_ff    <= '0;
         second_field_ff   <= '0;
         seconds_value_ff  <= '0;
         error_flag_ff     <= 1'b0;
         content_seen_ff   <= 1'b0;
         trailing_space_ff <= 1'b0;
      end else begin
         colon_count_ff    <= colon_count_in;
         in_fraction_ff    <= in_fraction_in;
         digit_count_ff    <= digit_count_in;
         current_value_ff  <= current_value_in;
         first_field_ff    <= first_field_in;
         second_field_ff   <= second_field_in;
         seconds_value_ff  <= seconds_value_in;
         error_flag_ff     <= error_flag_in;
         content_seen_ff   <= content_seen_in;
         trailing_space_ff <= trailing_space_in;
      end
   end

   a_bad_colon_is_error : assert property (@(posedge clock) disable iff (reset)
      (colon_count_ff == wtp_pkg::COLON_BAD) |-> error_flag_ff)
      else $error("third colon recorded without error");

   a_digit_count_sat : assert property (@(posedge clock) disable iff (reset)
      digit_count_ff <= wtp_pkg::DIGIT_SAT)
      else $error("digit count above saturation");

   a_trailing_needs_content : assert property (@(posedge clock) disable iff (reset)
      !content_seen_ff |-> !trailing_space_ff)
      else $error("trailing space before any content");

endmodule

`default_nettype wire

/* rtl/wtp_result.sv */
// Result side of the timestamp parser: finished-token register, millisecond
// sum, output register. Uses wtp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wtp_result #(
   parameter int VAL_W = 17
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      load,
   input  wire wtp_pkg::fin_type          fin,
   input  wire logic [VAL_W-1:0]          fin_hours,
   output      logic                      fin_ready,
   output      logic                      out_valid,
   input  wire logic                      out_stall,
   output      logic                      out_valid_res,
   output      logic [wtp_pkg::MS_W-1:0]  out_total_ms
);

   logic                     fin_valid_ff, fin_valid_in;
   wtp_pkg::fin_type         fin_ff;
   logic [VAL_W-1:0]         hours_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_valid_res_ff;
   logic [wtp_pkg::MS_W-1:0] rsp_total_ms_ff;
   logic                     out_ready;

   logic [VAL_W+21:0]        hour_ms;
   logic [21:0]              min_ms;
   logic [15:0]              sec_ms;
   logic [wtp_pkg::MS_W-1:0] total;

   assign out_ready = !rsp_valid_ff || !out_stall;
   assign fin_ready = !fin_valid_ff || out_ready;

   assign hour_ms = hours_ff * wtp_pkg::MS_PER_HOUR;
   assign min_ms  = fin_ff.minutes * wtp_pkg::MS_PER_MIN;
   assign sec_ms  = fin_ff.seconds * wtp_pkg::MS_PER_SEC;
   // wide limits wrap into the 38-bit field
   assign total   = wtp_pkg::MS_W'(hour_ms) + wtp_pkg::MS_W'(min_ms) +
                    wtp_pkg::MS_W'(sec_ms) + wtp_pkg::MS_W'(fin_ff.frac);

   always_comb begin
      fin_valid_in = fin_valid_ff;
      if (load) begin
         fin_valid_in = 1'b1;
      end else if (out_ready) begin
         fin_valid_in = 1'b0;
      end
      rsp_valid_in = out_ready ? fin_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fin_valid_ff <= fin_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (load) begin
         fin_ff   <= fin;
         hours_ff <= fin_hours;
      end
      if (out_ready) begin
         rsp_valid_res_ff <= fin_ff.ok;
         rsp_total_ms_ff  <= fin_ff.ok ? total : '0;
      end
   end

   assign out_valid     = rsp_valid_ff;
   assign out_valid_res = rsp_valid_res_ff;
   assign out_total_ms  = rsp_total_ms_ff;

   a_load_has_room : assert property (@(posedge clock) disable iff (reset)
      load |-> fin_ready)
      else $error("finished token loaded over a held one");

   a_invalid_is_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_valid_res_ff) |-> (rsp_total_ms_ff == '0))
      else $error("invalid token with nonzero time");

endmodule

`default_nettype wire

/* rtl/webvtt_timestamp_parser.sv */
// WebVTT timestamp parser: takes one byte of a [hh:]mm:ss.fff token per item
// and returns, on the byte flagged last, a valid flag and the time in whole
// milliseconds (zero when invalid). One byte is taken every clock cycle unless req_stall
// is high; the last byte of a token passes through the input buffer, then its result through
// the finished-token register and the output register. req_stall comes from a flop
// and rises only while rsp_stall holds back a finished token.
// Hours above HOURS_LIMIT make the token invalid. Uses wtp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module webvtt_timestamp_parser #(
   parameter int HOURS_LIMIT = 65535
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output      logic                     req_stall,
   input  wire logic [7:0]               req_char_code,
   input  wire logic                     req_is_last,
   output      logic                     rsp_valid,
   input  wire logic                     rsp_stall,
   output      logic                     rsp_valid_res,
   output      logic [wtp_pkg::MS_W-1:0] rsp_total_ms
);

   localparam int VAL_W = $clog2(HOURS_LIMIT + 2);

   wtp_pkg::char_type in_item;
   wtp_pkg::char_type hd_item;
   logic              hd_valid;
   logic              fin_ready;
   logic              consume;
   wtp_pkg::fin_type  fin;
   logic [VAL_W-1:0]  fin_hours;

   assign in_item.code = req_char_code;
   assign in_item.last = req_is_last;

   // a last byte waits until the result side has room
   assign consume = hd_valid && (!hd_item.last || fin_ready);

   wtp_skid u_skid (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_valid),
      .in_stall (req_stall),
      .in_item  (in_item),
      .hd_valid (hd_valid),
      .hd_item  (hd_item),
      .pop      (consume)
   );

   wtp_field_acc #(
      .HOURS_LIMIT (HOURS_LIMIT),
      .VAL_W       (VAL_W)
   ) u_field_acc (
      .clock     (clock),
      .reset     (reset),
      .take      (consume),
      .item      (hd_item),
      .fin       (fin),
      .fin_hours (fin_hours)
   );

   wtp_result #(
      .VAL_W (VAL_W)
   ) u_result (
      .clock         (clock),
      .reset         (reset),
      .load          (consume && hd_item.last),
      .fin           (fin),
      .fin_hours     (fin_hours),
      .fin_ready     (fin_ready),
      .out_valid     (rsp_valid),
      .out_stall     (rsp_stall),
      .out_valid_res (rsp_valid_res),
      .out_total_ms  (rsp_total_ms)
   );

   a_stall_needs_backpressure : assert property (@(posedge clock) disable iff (reset)
      !$past(rsp_stall) |-> !req_stall)
      else $error("input stalled without output backpressure");

endmodule

`default_nettype wire

/* tb/tb_webvtt_timestamp_parser.sv */
`timescale 1ns / 1ps

// Testbench for webvtt_timestamp_parser: streams timestamp tokens one byte per
// item with random gaps and stalls, and checks each result against its own parser.
// Depends on wtp_pkg and the parser RTL only.
module tb_webvtt_timestamp_parser;

   localparam int HOURS_LIMIT    = 65535;
   localparam int ACC_W          = $clog2(HOURS_LIMIT + 2);
   localparam int RAND_CHARS     = 1500;
   localparam int HOLD_CYCLES    = 400;
   localparam int HOLD_AFTER     = 60;
   localparam int SETTLE_CYCLES  = 12;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int MAX_REPORTS    = 10;
   localparam int PAUSE_EVERY    = 45;

   localparam logic [7:0] CHAR_LF       = 8'h0A;
   localparam logic [7:0] CHAR_VT       = 8'h0B;
   localparam logic [7:0] CHAR_FORMFEED = 8'h0C;
   localparam logic [7:0] CHAR_BS       = 8'h08;
   localparam logic [7:0] CHAR_SO       = 8'h0E;
   localparam logic [7:0] BYTE_NUL      = 8'h00;
   localparam logic [7:0] BYTE_MAX      = 8'hFF;

   typedef struct packed {
      wtp_pkg::char_type ch;
      logic              pause;
   } char_item_type;

   typedef struct packed {
      logic                     ok;
      logic [wtp_pkg::MS_W-1:0] ms;
   } stamp_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [7:0]               req_char_code = '0;
   logic                     req_is_last = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic                     rsp_valid_res;
   logic [wtp_pkg::MS_W-1:0] rsp_total_ms;

   char_item_type char_fifo[$];
   stamp_type     stamp_fifo[$];
   logic [7:0]    tok[$];

   int chars_queued = 0;
   int chars_taken = 0;
   int tokens_queued = 0;
   int fail_count = 0;
   int results_seen = 0;
   int idle_cycles = 0;
   int gap_left = 0;
   int send_calm = 0;
   int stall_left = 0;
   int recv_calm = 0;
   int hold_count = 0;
   logic hold_on = 1'b0;
   logic hold_done = 1'b0;
   char_item_type next_char;
   stamp_type want;

   // parser state
   logic [1:0]       n_colons;
   logic             seen_dot;
   logic [2:0]       n_digits;
   logic [ACC_W-1:0] field_acc;
   logic [ACC_W-1:0] lead_field;
   logic [6:0]       mid_field;
   logic [6:0]       sec_field;
   logic             bad_token;
   logic             got_content;
   logic             got_trail;

   webvtt_timestamp_parser #(
      .HOURS_LIMIT(HOURS_LIMIT)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_char_code(req_char_code),
      .req_is_last(req_is_last),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_valid_res(rsp_valid_res),
      .rsp_total_ms(rsp_total_ms)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic clear_parser();
      n_colons    = '0;
      seen_dot    = 1'b0;
      n_digits    = '0;
      field_acc   = '0;
      lead_field  = '0;
      mid_field   = '0;
      sec_field   = '0;
      bad_token   = 1'b0;
      got_content = 1'b0;
      got_trail   = 1'b0;
   endtask

   // Advance the parser by one byte; on the last byte queue the finished stamp.
   task automatic parse_char(input logic [7:0] c, input logic last);
      logic [63:0] acc;
      logic [63:0] hrs;
      logic [63:0] mins;
      logic [63:0] total;
      logic        good;
      stamp_type   stamp;
      if (c == wtp_pkg::CHAR_SPACE ||
          (c >= wtp_pkg::CHAR_TAB && c <= wtp_pkg::CHAR_CR)) begin
         if (got_content)
            got_trail = 1'b1;
      end else begin
         if (got_trail)
            bad_token = 1'b1;
         got_content = 1'b1;
         if (c >= wtp_pkg::CHAR_ZERO && c <= wtp_pkg::CHAR_NINE) begin
            acc = 64'(field_acc) * 64'd10 + 64'(c - wtp_pkg::CHAR_ZERO);
            field_acc = (acc > HOURS_LIMIT) ? ACC_W'(HOURS_LIMIT + 1) : acc[ACC_W-1:0];
            if (n_digits < wtp_pkg::DIGIT_SAT)
               n_digits++;
         end else if (c == wtp_pkg::CHAR_COLON) begin
            if (seen_dot || n_colons >= wtp_pkg::COLON_MAX) begin
               bad_token = 1'b1;
               n_colons  = wtp_pkg::COLON_BAD;
            end else begin
               if (n_colons == 2'd0)
                  lead_field = field_acc;
               else
                  mid_field = (field_acc > ACC_W'(wtp_pkg::SMALL_CAP)) ?
                              wtp_pkg::SMALL_CAP : field_acc[6:0];
               n_colons++;
            end
            if (n_digits < wtp_pkg::DIGIT_MIN)
               bad_token = 1'b1;
            field_acc = '0;
            n_digits  = '0;
         end else if (c == wtp_pkg::CHAR_DOT) begin
            if (seen_dot)
               bad_token = 1'b1;
            seen_dot  = 1'b1;
            sec_field = (field_acc > ACC_W'(wtp_pkg::SMALL_CAP)) ?
                        wtp_pkg::SMALL_CAP : field_acc[6:0];
            if (n_digits < wtp_pkg::DIGIT_MIN)
               bad_token = 1'b1;
            field_acc = '0;
            n_digits  = '0;
         end else begin
            bad_token = 1'b1;
         end
      end
      if (last) begin
         good = !bad_token && seen_dot && n_digits == wtp_pkg::FRAC_DIGITS &&
                sec_field < wtp_pkg::SIXTY;
         hrs  = '0;
         mins = '0;
         if (n_colons == wtp_pkg::COLON_MS) begin
            good = good && lead_field < ACC_W'(wtp_pkg::SIXTY);
            mins = 64'(lead_field);
         end else if (n_colons == wtp_pkg::COLON_HMS) begin
            good = good && mid_field < wtp_pkg::SIXTY && lead_field <= ACC_W'(HOURS_LIMIT);
            hrs  = 64'(lead_field);
            mins = 64'(mid_field);
         end else begin
            good = 1'b0;
         end
         total = hrs * 64'(wtp_pkg::MS_PER_HOUR) + mins * 64'(wtp_pkg::MS_PER_MIN) +
                 64'(sec_field) * 64'(wtp_pkg::MS_PER_SEC) + 64'(field_acc);
         stamp.ok = good;
         stamp.ms = good ? total[wtp_pkg::MS_W-1:0] : '0;
         stamp_fifo.push_back(stamp);
         clear_parser();
      end
   endtask

   // Idle length: mostly none or short, a few long, and now and then a calm stretch.
   task automatic pick_idle(inout int calm, output int n);
      int r;
      r = $urandom_range(0, 99);
      if (calm > 0) begin
         calm--;
         n = 0;
      end else if (r < 3) begin
         calm = $urandom_range(20, 80);
         n = 0;
      end else if (r < 55) begin
         n = 0;
      end else if (r < 93) begin
         n = $urandom_range(1, 3);
      end else begin
         n = $urandom_range(8, 40);
      end
   endtask

   task automatic log_failure(input string msg);
      fail_count++;
      if (fail_count <= MAX_REPORTS)
         $display("%s", msg);
   endtask

   task automatic add_str(input string s);
      for (int i = 0; i < s.len(); i++)
         tok.push_back(s[i]);
   endtask

   task automatic add_num(input int unsigned v, input int w);
      logic [7:0]  digs[$];
      int unsigned rest;
      rest = v;
      do begin
         digs.push_front(8'(wtp_pkg::CHAR_ZERO + rest % 10));
         rest = rest / 10;
      end while (rest != 0);
      while (digs.size() < w)
         digs.push_front(wtp_pkg::CHAR_ZERO);
      foreach (digs[i])
         tok.push_back(digs[i]);
   endtask

   task automatic add_ws(input int n);
      repeat (n) begin
         case ($urandom_range(0, 5))
            0: tok.push_back(wtp_pkg::CHAR_SPACE);
            1: tok.push_back(wtp_pkg::CHAR_TAB);
            2: tok.push_back(CHAR_LF);
            3: tok.push_back(CHAR_VT);
            4: tok.push_back(CHAR_FORMFEED);
            default: tok.push_back(wtp_pkg::CHAR_CR);
         endcase
      end
   endtask

   // Move the built token into the send queue, last flag on its final byte.
   task automatic flush_token(input logic pause);
      char_item_type item;
      if (tok.size() == 0)
         tok.push_back(wtp_pkg::CHAR_SPACE);
      foreach (tok[i]) begin
         item.ch.code = tok[i];
         item.ch.last = (i == tok.size() - 1);
         item.pause   = pause && (i == 0);
         char_fifo.push_back(item);
      end
      chars_queued += tok.size();
      tokens_queued++;
      tok.delete();
   endtask

   function automatic int sexagesimal();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(60, 99) : $urandom_range(0, 59);
   endfunction

   function automatic int field_width(input int w);
      return ($urandom_range(0, 24) == 0) ? $urandom_range(w - 1, w + 1) : w;
   endfunction

   // Driver: hold a stalled item, otherwise present the next one after its gap.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
         send_calm = 0;
         chars_taken = 0;
         stamp_fifo.delete();
         clear_parser();
      end else begin
         if (req_valid && !req_stall) begin
            parse_char(req_char_code, req_is_last);
            chars_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (char_fifo.size() != 0 &&
                         !(char_fifo[0].pause && stamp_fifo.size() != 0)) begin
               next_char = char_fifo.pop_front();
               req_valid     <= 1'b1;
               req_char_code <= next_char.ch.code;
               req_is_last   <= next_char.ch.last;
               pick_idle(send_calm, gap_left);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each accepted result with the oldest queued stamp.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         results_seen <= 0;
         stall_left = 0;
         recv_calm = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen <= results_seen + 1;
            if (stamp_fifo.size() == 0) begin
               log_failure($sformatf(
                  "result %0d arrived with nothing expected: valid_res %0b total_ms %0d",
                  results_seen, rsp_valid_res, rsp_total_ms));
            end else begin
               want = stamp_fifo.pop_front();
               if (rsp_valid_res !== want.ok)
                  log_failure($sformatf("result %0d: valid_res expected %0b got %0b",
                                        results_seen, want.ok, rsp_valid_res));
               if (rsp_total_ms !== want.ms)
                  log_failure($sformatf("result %0d: total_ms expected %0d got %0d",
                                        results_seen, want.ms, rsp_total_ms));
            end
         end
         if (stall_left == 0)
            pick_idle(recv_calm, stall_left);
         else
            stall_left--;
         rsp_stall <= hold_on || (stall_left != 0);
      end
   end

   // Long receiver hold-off once, so the parser backs up and stalls its input.
   always @(posedge clock) begin
      if (reset) begin
         hold_on    <= 1'b0;
         hold_done  <= 1'b0;
         hold_count <= 0;
      end else if (hold_on) begin
         hold_count <= hold_count + 1;
         if (hold_count == HOLD_CYCLES - 1) begin
            hold_on   <= 1'b0;
            hold_done <= 1'b1;
         end
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
         hold_on <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("** webvtt_timestamp_parser: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int         kind;
      int         m;
      int         pos;
      int         rand_floor;
      logic [7:0] b;

      // directed tokens
      add_str("00:00.000");             flush_token(1'b0);
      add_str("59:59.999");             flush_token(1'b0);
      add_str("65535:59:59.999");       flush_token(1'b0);
      add_str("65536:00:00.000");       flush_token(1'b0);
      add_str("00:00:00.000");          flush_token(1'b0);
      add_str("99999999999:00:00.000"); flush_token(1'b0);
      tok.push_back(wtp_pkg::CHAR_SPACE);
      tok.push_back(wtp_pkg::CHAR_TAB);
      add_str("12:34.567");
      tok.push_back(wtp_pkg::CHAR_CR);
      tok.push_back(CHAR_LF);
      flush_token(1'b0);
      add_str("12:34 .567");            flush_token(1'b0);
      add_str("1:23.456");              flush_token(1'b0);
      add_str(":00.000");               flush_token(1'b0);
      add_str("12:34.56");              flush_token(1'b0);
      add_str("12:34.5678");            flush_token(1'b0);
      add_str("00:12:34:56.000");       flush_token(1'b0);
      add_str("12:34.5:67");            flush_token(1'b0);
      add_str("12:34.56.7");            flush_token(1'b0);
      add_str("12.345");                flush_token(1'b0);
      add_str(" ");                     flush_token(1'b0);
      add_str("12:60.000");             flush_token(1'b0);
      add_str("60:00.000");             flush_token(1'b0);
      add_str("01:60:00.000");          flush_token(1'b0);
      add_str("1a:00.000");             flush_token(1'b0);
      add_str("00:00.00");
      tok.push_back(BYTE_MAX);
      flush_token(1'b0);
      tok.push_back(BYTE_NUL);
      add_str("00:00.000");
      flush_token(1'b0);
      tok.push_back(CHAR_BS);
      add_str("00:00.000");
      tok.push_back(CHAR_SO);
      flush_token(1'b0);

      // random tokens: mostly well formed, some mutated, some pure noise
      rand_floor = chars_queued + RAND_CHARS;
      while (chars_queued < rand_floor) begin
         kind = $urandom_range(0, 99);
         if (kind < 8) begin
            repeat ($urandom_range(1, 10))
               tok.push_back(8'($urandom_range(0, 255)));
         end else begin
            if ($urandom_range(0, 3) == 0)
               add_ws($urandom_range(1, 3));
            if ($urandom_range(0, 1) == 1) begin
               m = $urandom_range(0, 99);
               if (m < 70)
                  add_num($urandom_range(0, 99), 2);
               else if (m < 85)
                  add_num($urandom_range(0, HOURS_LIMIT), $urandom_range(2, 5));
               else
                  add_num($urandom_range(HOURS_LIMIT - 2, HOURS_LIMIT + 2), 2);
               tok.push_back(wtp_pkg::CHAR_COLON);
            end
            add_num(sexagesimal(), field_width(2));
            tok.push_back(wtp_pkg::CHAR_COLON);
            add_num(sexagesimal(), field_width(2));
            tok.push_back(wtp_pkg::CHAR_DOT);
            add_num($urandom_range(0, 999), field_width(3));
            if ($urandom_range(0, 3) == 0)
               add_ws($urandom_range(1, 3));
            if (kind >= 78) begin
               pos = $urandom_range(0, tok.size() - 1);
               case ($urandom_range(0, 3))
                  0: tok[pos] = 8'($urandom_range(0, 255));
                  1: if (tok.size() > 1) tok.delete(pos);
                  2: begin
                     case ($urandom_range(0, 4))
                        0: b = wtp_pkg::CHAR_COLON;
                        1: b = wtp_pkg::CHAR_DOT;
                        2: b = wtp_pkg::CHAR_SPACE;
                        3: b = 8'(wtp_pkg::CHAR_ZERO + $urandom_range(0, 9));
                        default: b = 8'($urandom_range(0, 255));
                     endcase
                     tok.insert(pos, b);
                  end
                  default: while (tok.size() > pos + 1) tok.pop_back();
               endcase
            end
         end
         // drain every result before some tokens
         flush_token(tokens_queued % PAUSE_EVERY == PAUSE_EVERY - 1);
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (chars_taken != chars_queued || stamp_fifo.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && stamp_fifo.size() == 0)
         $display("** webvtt_timestamp_parser: PASSED **");
      else
         $display("** webvtt_timestamp_parser: FAILED **");
      $finish;
   end

endmodule
